/* src/assert_macros.svh */
// Assertion macros shared by the warp address pipeline.
// Depends on nothing; included by the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PWA_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("pwa check failed");
`define PWA_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("pwa check failed");
`else
`define PWA_ASSERT(name, clk, rst, prop)
`define PWA_ASSERT_ALWAYS(name, clk, prop)
`endif
`endif

/* src/pwa_pkg.sv */
// Types and constants of the perspective warp address pipeline.
// Depends on nothing; used by every pwa module.
package pwa_pkg;
   localparam int COEF_W    = 48;
   localparam int COORD_W   = 11;
   localparam int OFS_W     = 23;
   localparam int PROD_W    = 60;
   localparam int ACC_W     = 61;
   localparam int QBITS     = 12;
   localparam int CMP_W     = ACC_W + QBITS;
   localparam int NUM_CSR   = 8;
   localparam int CSR_IDX_W = 3;
   localparam int DIV_STEPS = 2;
   localparam int DIV_STAGES = QBITS / DIV_STEPS;
   localparam int NUM_ST    = DIV_STAGES + 4;
   localparam logic signed [ACC_W-1:0] Q_ONE = ACC_W'(64'sd1 <<< 32);

   localparam logic [CSR_IDX_W-1:0] CSR_X_GAIN_COL = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_X_GAIN_ROW = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_X_OFFSET   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_GAIN_COL = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_GAIN_ROW = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_OFFSET   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_W_GAIN_COL = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_W_GAIN_ROW = 3'd7;

   localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(64'sd1 <<< 32);

   typedef logic signed [COEF_W-1:0] coef_type;
   typedef coef_type coef_bank_type [NUM_CSR];

   typedef struct packed {
      logic [COORD_W-1:0] out_col;
      logic [COORD_W-1:0] out_row;
   } req_type;

   typedef struct packed {
      logic [COORD_W-1:0] src_col;
      logic [COORD_W-1:0] src_row;
      logic               src_valid;
      logic [OFS_W-1:0]   src_byte_offset;
      logic [OFS_W-1:0]   dst_byte_offset;
   } rsp_type;

   typedef struct packed {
      logic signed [PROD_W-1:0] xc, xr, yc, yr, wc, wr;
      logic [OFS_W-1:0]         dst;
   } prod_type;

   typedef struct packed {
      logic signed [ACC_W-1:0] nx, ny, dn;
      logic [OFS_W-1:0]        dst;
   } sum_type;

   typedef struct packed {
      logic [ACC_W-1:0] rem_x, rem_y, den;
      logic [QBITS-1:0] q_x, q_y;
      logic             neg_x, neg_y, bad;
      logic [OFS_W-1:0] dst;
   } div_type;
endpackage

/* src/pwa_mul.sv */
// Product stage: coefficient times coordinate, plus destination offset.
// Depends on pwa_pkg.
module pwa_mul #(
   parameter int FRAME_WIDTH     = 1920,
   parameter int BYTES_PER_PIXEL = 3
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  pwa_pkg::req_type       in_data,
   input  pwa_pkg::coef_bank_type coef,
   output logic                   out_valid,
   output pwa_pkg::prod_type      out_data
);
   logic              valid_ff;
   pwa_pkg::prod_type data_ff, data_in;
   logic signed [pwa_pkg::COORD_W:0] c, r;
   logic [31:0] lin;

   always_comb begin
      c = $signed({1'b0, in_data.out_col});
      r = $signed({1'b0, in_data.out_row});
      lin = (32'(in_data.out_row) * 32'(FRAME_WIDTH) + 32'(in_data.out_col))
            * 32'(BYTES_PER_PIXEL);
      data_in.xc  = coef[pwa_pkg::CSR_X_GAIN_COL] * c;
      data_in.xr  = coef[pwa_pkg::CSR_X_GAIN_ROW] * r;
      data_in.yc  = coef[pwa_pkg::CSR_Y_GAIN_COL] * c;
      data_in.yr  = coef[pwa_pkg::CSR_Y_GAIN_ROW] * r;
      data_in.wc  = coef[pwa_pkg::CSR_W_GAIN_COL] * c;
      data_in.wr  = coef[pwa_pkg::CSR_W_GAIN_ROW] * r;
      data_in.dst = lin[pwa_pkg::OFS_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule

/* src/pwa_sum.sv */
// Sum stage: numerators and denominator in Q.32.
// Depends on pwa_pkg.
module pwa_sum (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  pwa_pkg::prod_type      in_data,
   input  pwa_pkg::coef_bank_type coef,
   output logic                   out_valid,
   output pwa_pkg::sum_type       out_data
);
   logic             valid_ff;
   pwa_pkg::sum_type data_ff, data_in;

   always_comb begin
      data_in.nx = pwa_pkg::ACC_W'(in_data.xc) + pwa_pkg::ACC_W'(in_data.xr)
                 + pwa_pkg::ACC_W'(coef[pwa_pkg::CSR_X_OFFSET]);
      data_in.ny = pwa_pkg::ACC_W'(in_data.yc) + pwa_pkg::ACC_W'(in_data.yr)
                 + pwa_pkg::ACC_W'(coef[pwa_pkg::CSR_Y_OFFSET]);
      data_in.dn = pwa_pkg::ACC_W'(in_data.wc) + pwa_pkg::ACC_W'(in_data.wr)
                 + pwa_pkg::Q_ONE;
      data_in.dst = in_data.dst;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule

/* src/pwa_prep.sv */
// Divide setup: magnitudes, quotient signs, range and zero checks.
// Depends on pwa_pkg.
module pwa_prep (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  pwa_pkg::sum_type in_data,
   output logic             out_valid,
   output pwa_pkg::div_type out_data
);
   logic             valid_ff;
   pwa_pkg::div_type data_ff, data_in;
   logic [pwa_pkg::ACC_W-1:0] mx, my, md;
   logic [pwa_pkg::CMP_W-1:0] dlim;

   always_comb begin
      mx = in_data.nx[pwa_pkg::ACC_W-1] ? pwa_pkg::ACC_W'(-in_data.nx) : in_data.nx;
      my = in_data.ny[pwa_pkg::ACC_W-1] ? pwa_pkg::ACC_W'(-in_data.ny) : in_data.ny;
      md = in_data.dn[pwa_pkg::ACC_W-1] ? pwa_pkg::ACC_W'(-in_data.dn) : in_data.dn;
      dlim = {md, {pwa_pkg::QBITS{1'b0}}};
      data_in.rem_x = mx;
      data_in.rem_y = my;
      data_in.den   = md;
      data_in.q_x   = '0;
      data_in.q_y   = '0;
      data_in.neg_x = in_data.nx[pwa_pkg::ACC_W-1] ^ in_data.dn[pwa_pkg::ACC_W-1];
      data_in.neg_y = in_data.ny[pwa_pkg::ACC_W-1] ^ in_data.dn[pwa_pkg::ACC_W-1];
      data_in.bad   = (md == '0) || (pwa_pkg::CMP_W'(mx) >= dlim)
                   || (pwa_pkg::CMP_W'(my) >= dlim);
      data_in.dst   = in_data.dst;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule

/* src/pwa_div_step.sv */
// Restoring divide stage: two quotient bits for both axes.
// Depends on pwa_pkg.
module pwa_div_step #(
   parameter int TOP_BIT = 11
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  pwa_pkg::div_type in_data,
   output logic             out_valid,
   output pwa_pkg::div_type out_data
);
   logic             valid_ff;
   pwa_pkg::div_type data_ff, data_in;
   logic [pwa_pkg::CMP_W-1:0] dsh;

   always_comb begin
      data_in = in_data;
      for (int j = 0; j < pwa_pkg::DIV_STEPS; j++) begin
         dsh = pwa_pkg::CMP_W'(in_data.den) << (TOP_BIT - j);
         if (pwa_pkg::CMP_W'(data_in.rem_x) >= dsh) begin
            data_in.rem_x = data_in.rem_x - dsh[pwa_pkg::ACC_W-1:0];
            data_in.q_x[TOP_BIT-j] = 1'b1;
         end
         if (pwa_pkg::CMP_W'(data_in.rem_y) >= dsh) begin
            data_in.rem_y = data_in.rem_y - dsh[pwa_pkg::ACC_W-1:0];
            data_in.q_y[TOP_BIT-j] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule

/* src/perspective_warp_address.sv */
// Perspective warp address generator, top level.
// Depends on pwa_pkg, assert_macros.svh and the pwa stage modules.
//
// One word enters per clock while req_stall is low, and one result word leaves per word, in order.
// The stages are product, sum, divide setup, six restoring divide stages
// of two quotient bits each, and the output register. Each stage
// holds only while the stage after it is full and held, so a stalled
// output fills bubbles before the input stalls.
`include "assert_macros.svh"
module perspective_warp_address #(
   parameter int FRAME_WIDTH     = 1920,
   parameter int FRAME_HEIGHT    = 1080,
   parameter int BYTES_PER_PIXEL = 3
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  pwa_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output pwa_pkg::rsp_type                rsp_data,
   input  logic                            csr_we,
   input  logic [pwa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pwa_pkg::COEF_W-1:0]      csr_data
);
   localparam int ND = pwa_pkg::DIV_STAGES;

   pwa_pkg::coef_bank_type coef_ff;
   logic [pwa_pkg::NUM_ST-1:0] en;
   logic [pwa_pkg::NUM_ST-2:0] v;
   pwa_pkg::prod_type prod;
   pwa_pkg::sum_type  sum;
   pwa_pkg::div_type  dv [ND+1];
   logic              dvv [ND+1];
   logic              rsp_valid_ff;
   pwa_pkg::rsp_type  rsp_ff, rsp_in;
   logic [31:0]       soff;
   logic              ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff[pwa_pkg::CSR_X_GAIN_COL] <= pwa_pkg::COEF_ONE;
         coef_ff[pwa_pkg::CSR_X_GAIN_ROW] <= '0;
         coef_ff[pwa_pkg::CSR_X_OFFSET]   <= '0;
         coef_ff[pwa_pkg::CSR_Y_GAIN_COL] <= '0;
         coef_ff[pwa_pkg::CSR_Y_GAIN_ROW] <= pwa_pkg::COEF_ONE;
         coef_ff[pwa_pkg::CSR_Y_OFFSET]   <= '0;
         coef_ff[pwa_pkg::CSR_W_GAIN_COL] <= '0;
         coef_ff[pwa_pkg::CSR_W_GAIN_ROW] <= '0;
      end else if (csr_we) begin
         coef_ff[csr_index] <= $signed(csr_data);
      end
   end

   always_comb begin
      en[pwa_pkg::NUM_ST-1] = !rsp_valid_ff || !rsp_stall;
      for (int k = pwa_pkg::NUM_ST-2; k >= 0; k--) en[k] = !v[k] || en[k+1];
   end
   assign req_stall = !en[0];

   pwa_mul #(.FRAME_WIDTH(FRAME_WIDTH), .BYTES_PER_PIXEL(BYTES_PER_PIXEL)) u_mul (
      .clock, .reset, .en(en[0]), .in_valid(req_valid), .in_data(req_data),
      .coef(coef_ff), .out_valid(v[0]), .out_data(prod)
   );

   pwa_sum u_sum (
      .clock, .reset, .en(en[1]), .in_valid(v[0]), .in_data(prod),
      .coef(coef_ff), .out_valid(v[1]), .out_data(sum)
   );

   pwa_prep u_prep (
      .clock, .reset, .en(en[2]), .in_valid(v[1]), .in_data(sum),
      .out_valid(dvv[0]), .out_data(dv[0])
   );
   assign v[2] = dvv[0];

   for (genvar s = 0; s < ND; s++) begin : g_div
      pwa_div_step #(.TOP_BIT(pwa_pkg::QBITS - 1 - s * pwa_pkg::DIV_STEPS)) u_step (
         .clock, .reset, .en(en[3+s]), .in_valid(dvv[s]), .in_data(dv[s]),
         .out_valid(dvv[s+1]), .out_data(dv[s+1])
      );
      assign v[3+s] = dvv[s+1];
   end

   always_comb begin
      ok = !dv[ND].bad
         && (!dv[ND].neg_x || (dv[ND].q_x == '0))
         && (!dv[ND].neg_y || (dv[ND].q_y == '0))
         && (32'(dv[ND].q_x) < 32'(FRAME_WIDTH))
         && (32'(dv[ND].q_y) < 32'(FRAME_HEIGHT));
      soff = (32'(dv[ND].q_y) * 32'(FRAME_WIDTH) + 32'(dv[ND].q_x))
             * 32'(BYTES_PER_PIXEL);
      rsp_in.src_valid       = ok;
      rsp_in.src_col         = ok ? dv[ND].q_x[pwa_pkg::COORD_W-1:0] : '0;
      rsp_in.src_row         = ok ? dv[ND].q_y[pwa_pkg::COORD_W-1:0] : '0;
      rsp_in.src_byte_offset = ok ? soff[pwa_pkg::OFS_W-1:0] : '0;
      rsp_in.dst_byte_offset = dv[ND].dst;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en[pwa_pkg::NUM_ST-1]) begin
         rsp_valid_ff <= dvv[ND];
      end
      if (en[pwa_pkg::NUM_ST-1]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `PWA_ASSERT(a_stall_only_when_full, clock, reset, req_stall |-> (rsp_valid && rsp_stall))
   `PWA_ASSERT(a_invalid_zeroed, clock, reset, (rsp_valid && !rsp_data.src_valid) |-> ((rsp_data.src_col == '0) && (rsp_data.src_row == '0) && (rsp_data.src_byte_offset == '0)))
   `PWA_ASSERT(a_src_in_frame, clock, reset, (rsp_valid && rsp_data.src_valid) |-> ((32'(rsp_data.src_col) < 32'(FRAME_WIDTH)) && (32'(rsp_data.src_row) < 32'(FRAME_HEIGHT))))
endmodule
